@@ hw/rtl/canx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// canx_pkg: shared types and constants
// Frame and update structures, identifiers and fixed-point reciprocals used
// by the CAN telemetry signal extractor.
// ----------------------------------------------------------------------------
package canx_pkg;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic [31:0] now_ms;
    } t_frame;

    // payload bytes: index 7 is payload byte 0 (bits 63..56)
    typedef logic [7:0][7:0] t_payload;

    typedef struct packed {
        logic     accepted;
        logic     drive_touch;
        logic     motion_touch;
        logic [7:0] drive_be;
        logic [7:0] motion_be;
        t_payload drive_data;
        t_payload motion_data;
    } t_update;

    localparam logic [10:0] ID_STEER = 11'h076;
    localparam logic [10:0] ID_SPEED = 11'h077;
    localparam logic [10:0] ID_BRAKE = 11'h07D;
    localparam logic [10:0] ID_RPM   = 11'h204;
    localparam logic [10:0] ID_LONG  = 11'h213;
    localparam logic [10:0] ID_GEAR  = 11'h230;
    localparam logic [10:0] ID_LOAD  = 11'h43E;

    localparam logic [15:0] STEER_BASE  = 16'd1600;
    localparam logic [13:0] LAT_OFFSET  = 14'd2048;
    localparam logic [7:0]  LOAD_BIAS   = 8'd136;
    localparam logic [7:0]  LOAD_LIMIT  = 8'h43;
    localparam logic [3:0]  GEAR_MIN    = 4'd1;
    localparam logic [3:0]  GEAR_MAX    = 4'd10;

    // x/10 = (x * DIV10_MUL) >> 19, exact below 2^18
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    // x/9 = (x * DIV9_MUL) >> 16, exact below 2^15
    localparam logic [31:0] DIV9_MUL    = 32'd7282;
    // x*364/1000 = (x * LONG_MUL) >> 20, exact for x up to 512
    localparam logic [31:0] LONG_MUL    = 32'd381682;

endpackage
`default_nettype wire

@@ hw/rtl/canx_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// canx interfaces
// Valid/ready channels for received frames and telemetry results.
// ----------------------------------------------------------------------------
interface canx_frame_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic [31:0] now_ms;

    modport source (
        output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
               byte7, now_ms,
        input  ready
    );
    modport sink (
        input  valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5, byte6,
               byte7, now_ms,
        output ready
    );
endinterface

interface canx_telem_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [63:0] drive_payload;
    logic [63:0] motion_payload;
    logic [31:0] drive_stamp;
    logic [31:0] motion_stamp;
    logic [31:0] accepted_total;
    logic [31:0] ignored_total;

    modport source (
        output valid, accepted, drive_payload, motion_payload, drive_stamp,
               motion_stamp, accepted_total, ignored_total,
        input  ready
    );
    modport sink (
        input  valid, accepted, drive_payload, motion_payload, drive_stamp,
               motion_stamp, accepted_total, ignored_total,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/canx_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// canx_decode: signal extraction
// Decodes one registered frame into byte writes for the drive and motion
// payloads.
// ----------------------------------------------------------------------------
module canx_decode (
    input  wire canx_pkg::t_frame  i_frame,
    output canx_pkg::t_update      o_upd
);

    logic [15:0] w_b01;
    logic [31:0] w_steer_prod;
    logic [15:0] w_steer;

    logic [12:0] w_lat_raw;
    logic [13:0] w_lat_diff;
    logic [13:0] w_lat_adj;
    logic [15:0] w_lat;

    logic [13:0] w_brk_in;
    logic [31:0] w_brk_prod;
    logic [15:0] w_brk;

    logic [15:0] w_rpm;

    logic [9:0]  w_ped_in;
    logic [31:0] w_ped_prod;
    logic [7:0]  w_ped;

    logic [9:0]  w_lon_raw;
    logic        w_lon_neg;
    logic [9:0]  w_lon_v;
    logic [9:0]  w_lon_mag;
    logic [31:0] w_lon_prod;
    logic [15:0] w_lon_q;
    logic [15:0] w_lon;

    logic [7:0]  w_flags;
    logic [3:0]  w_gear_raw;
    logic [7:0]  w_gear;

    logic [12:0] w_load_in;
    logic [31:0] w_load_prod;
    logic [7:0]  w_load;

    assign w_b01        = {i_frame.byte0, i_frame.byte1};
    assign w_steer_prod = 32'(w_b01) * canx_pkg::DIV10_MUL;
    assign w_steer      = canx_pkg::STEER_BASE - {3'b000, w_steer_prod[31:19]};

    assign w_lat_raw  = {i_frame.byte2[4:0], i_frame.byte3};
    assign w_lat_diff = {1'b0, w_lat_raw} - canx_pkg::LAT_OFFSET;
    // round toward zero before the halving shift
    assign w_lat_adj  = w_lat_diff + {13'd0, w_lat_diff[13]};
    assign w_lat      = {{3{w_lat_adj[13]}}, w_lat_adj[13:1]};

    assign w_brk_in   = {i_frame.byte3[3:0], i_frame.byte4, 2'b00};
    assign w_brk_prod = 32'(w_brk_in) * canx_pkg::DIV10_MUL;
    assign w_brk      = {3'b000, w_brk_prod[31:19]};

    assign w_rpm      = {2'b00, i_frame.byte3[4:0], i_frame.byte4, 1'b0};

    assign w_ped_in   = {i_frame.byte0[1:0], i_frame.byte1};
    assign w_ped_prod = 32'(w_ped_in) * canx_pkg::DIV10_MUL;
    assign w_ped      = w_ped_prod[26:19];

    // raw - 512 on ten bits is the raw value with its top bit inverted
    assign w_lon_raw  = {i_frame.byte5[1:0], i_frame.byte6};
    assign w_lon_v    = {~w_lon_raw[9], w_lon_raw[8:0]};
    assign w_lon_neg  = w_lon_v[9];
    assign w_lon_mag  = w_lon_neg ? (~w_lon_v + 10'd1) : w_lon_v;
    assign w_lon_prod = 32'(w_lon_mag) * canx_pkg::LONG_MUL;
    assign w_lon_q    = {8'd0, w_lon_prod[27:20]};
    assign w_lon      = w_lon_neg ? (~w_lon_q + 16'd1) : w_lon_q;

    assign w_flags    = {6'd0, i_frame.byte2[7], i_frame.byte3[7]};

    assign w_gear_raw = i_frame.byte0[7:4];
    assign w_gear     = (w_gear_raw inside {[canx_pkg::GEAR_MIN:canx_pkg::GEAR_MAX]})
                        ? {4'd0, w_gear_raw} : 8'd0;

    // /72 taken as >>3 then /9
    assign w_load_in   = {i_frame.byte5, i_frame.byte6[7:3]};
    assign w_load_prod = 32'(w_load_in) * canx_pkg::DIV9_MUL;
    assign w_load      = w_load_prod[23:16] - canx_pkg::LOAD_BIAS;

    always_comb begin
        o_upd              = '0;
        o_upd.accepted     = 1'b1;
        case (i_frame.frame_id)
            canx_pkg::ID_STEER: begin
                o_upd.motion_be[3]   = 1'b1;
                o_upd.motion_be[2]   = 1'b1;
                o_upd.motion_data[3] = w_steer[15:8];
                o_upd.motion_data[2] = w_steer[7:0];
                o_upd.motion_touch   = 1'b1;
            end
            canx_pkg::ID_SPEED: begin
                o_upd.drive_be[7]    = 1'b1;
                o_upd.drive_be[6]    = 1'b1;
                o_upd.drive_data[7]  = w_b01[15:8];
                o_upd.drive_data[6]  = w_b01[7:0];
                o_upd.drive_touch    = 1'b1;
                o_upd.motion_be[7]   = 1'b1;
                o_upd.motion_be[6]   = 1'b1;
                o_upd.motion_data[7] = w_lat[15:8];
                o_upd.motion_data[6] = w_lat[7:0];
                o_upd.motion_touch   = 1'b1;
            end
            canx_pkg::ID_BRAKE: begin
                o_upd.drive_be[1]    = 1'b1;
                o_upd.drive_be[0]    = 1'b1;
                o_upd.drive_data[1]  = w_brk[15:8];
                o_upd.drive_data[0]  = w_brk[7:0];
                o_upd.drive_touch    = 1'b1;
            end
            canx_pkg::ID_RPM: begin
                o_upd.drive_be[5]    = 1'b1;
                o_upd.drive_be[4]    = 1'b1;
                o_upd.drive_be[2]    = 1'b1;
                o_upd.drive_data[5]  = w_rpm[15:8];
                o_upd.drive_data[4]  = w_rpm[7:0];
                o_upd.drive_data[2]  = w_ped;
                o_upd.drive_touch    = 1'b1;
            end
            canx_pkg::ID_LONG: begin
                o_upd.motion_be[5]   = 1'b1;
                o_upd.motion_be[4]   = 1'b1;
                o_upd.motion_be[0]   = 1'b1;
                o_upd.motion_data[5] = w_lon[15:8];
                o_upd.motion_data[4] = w_lon[7:0];
                o_upd.motion_data[0] = w_flags;
                o_upd.motion_touch   = 1'b1;
            end
            canx_pkg::ID_GEAR: begin
                o_upd.motion_be[1]   = 1'b1;
                o_upd.motion_data[1] = w_gear;
                o_upd.motion_touch   = 1'b1;
            end
            canx_pkg::ID_LOAD: begin
                // out-of-range load: counted, nothing written
                if (i_frame.byte5 < canx_pkg::LOAD_LIMIT) begin
                    o_upd.drive_be[3]   = 1'b1;
                    o_upd.drive_data[3] = w_load;
                    o_upd.drive_touch   = 1'b1;
                end
            end
            default: begin
                o_upd.accepted = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/can_signal_extract_compose.sv @@
`default_nettype none
// Accepted frames pass the input register and then the result registers.
// Throughput: one item per cycle unless stalled; input register, decode logic,
// result/state register; back-pressure stalls the result and a full input register.
// Reset (synchronous, active low) clears payloads, stamps, counters and valids.
// ----------------------------------------------------------------------------
// can_signal_extract_compose: CAN telemetry signal extractor
// Decodes received frames into two stored telemetry payloads with stamps
// and accepted/ignored frame counters.
// ----------------------------------------------------------------------------
module can_signal_extract_compose (
    input  wire          i_clk,
    input  wire          i_rst_n,
    canx_frame_if.sink   i_frame,
    canx_telem_if.source o_telem
);

    logic                 r_in_valid;
    canx_pkg::t_frame     r_in;
    logic                 r_out_valid;
    logic                 r_accepted;
    canx_pkg::t_payload   r_drive;
    canx_pkg::t_payload   r_motion;
    logic [31:0]          r_drive_stamp;
    logic [31:0]          r_motion_stamp;
    logic [31:0]          r_acc_total;
    logic [31:0]          r_ign_total;

    canx_pkg::t_payload   n_drive;
    canx_pkg::t_payload   n_motion;
    canx_pkg::t_update    w_upd;
    logic                 w_advance;
    logic                 w_in_fire;

    assign w_advance     = r_in_valid && (!r_out_valid || o_telem.ready);
    assign i_frame.ready = !r_in_valid || w_advance;
    assign w_in_fire     = i_frame.valid && i_frame.ready;

    canx_decode u_decode (
        .i_frame (r_in),
        .o_upd   (w_upd)
    );

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_drive[k]  = w_upd.drive_be[k]  ? w_upd.drive_data[k]  : r_drive[k];
            n_motion[k] = w_upd.motion_be[k] ? w_upd.motion_data[k] : r_motion[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.frame_id <= i_frame.frame_id;
            r_in.byte0    <= i_frame.byte0;
            r_in.byte1    <= i_frame.byte1;
            r_in.byte2    <= i_frame.byte2;
            r_in.byte3    <= i_frame.byte3;
            r_in.byte4    <= i_frame.byte4;
            r_in.byte5    <= i_frame.byte5;
            r_in.byte6    <= i_frame.byte6;
            r_in.byte7    <= i_frame.byte7;
            r_in.now_ms   <= i_frame.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_accepted     <= 1'b0;
            r_drive        <= '0;
            r_motion       <= '0;
            r_drive_stamp  <= '0;
            r_motion_stamp <= '0;
            r_acc_total    <= '0;
            r_ign_total    <= '0;
        end else begin
            if (i_frame.ready) begin
                r_in_valid <= i_frame.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_accepted  <= w_upd.accepted;
                r_drive     <= n_drive;
                r_motion    <= n_motion;
                if (w_upd.drive_touch) begin
                    r_drive_stamp <= r_in.now_ms;
                end
                if (w_upd.motion_touch) begin
                    r_motion_stamp <= r_in.now_ms;
                end
                if (w_upd.accepted) begin
                    r_acc_total <= r_acc_total + 32'd1;
                end else begin
                    r_ign_total <= r_ign_total + 32'd1;
                end
            end else if (o_telem.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_telem.valid          = r_out_valid;
    assign o_telem.accepted       = r_accepted;
    assign o_telem.drive_payload  = r_drive;
    assign o_telem.motion_payload = r_motion;
    assign o_telem.drive_stamp    = r_drive_stamp;
    assign o_telem.motion_stamp   = r_motion_stamp;
    assign o_telem.accepted_total = r_acc_total;
    assign o_telem.ignored_total  = r_ign_total;

endmodule
`default_nettype wire

@@ hw/rtl/canx_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// canx_checker: port-level checks
// Result channel stability, reset behaviour and counter/payload consistency
// between successive delivered items.
// ----------------------------------------------------------------------------
module canx_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire        i_accepted,
    input wire [63:0] i_drive_payload,
    input wire [63:0] i_motion_payload,
    input wire [31:0] i_drive_stamp,
    input wire [31:0] i_motion_stamp,
    input wire [31:0] i_acc_total,
    input wire [31:0] i_ign_total
);

    logic        r_seen;
    logic [31:0] r_acc;
    logic [31:0] r_ign;
    logic [63:0] r_drive;
    logic [63:0] r_motion;
    logic [31:0] r_dstamp;
    logic [31:0] r_mstamp;
    logic        w_out_fire;
    logic [31:0] w_sum_now;
    logic [31:0] w_sum_next;

    assign w_out_fire = i_out_valid && i_out_ready;
    assign w_sum_now  = i_acc_total + i_ign_total;
    assign w_sum_next = r_acc + r_ign + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_out_fire) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_acc    <= i_acc_total;
            r_ign    <= i_ign_total;
            r_drive  <= i_drive_payload;
            r_motion <= i_motion_payload;
            r_dstamp <= i_drive_stamp;
            r_mstamp <= i_motion_stamp;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_accepted) && $stable(i_acc_total)
            && $stable(i_ign_total) && $stable(i_drive_payload)
            && $stable(i_motion_payload))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && r_seen |-> w_sum_now == w_sum_next)
        else $error("counters did not advance by one item");

    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && r_seen && i_accepted |-> i_acc_total == r_acc + 32'd1)
        else $error("accepted counter mismatch");

    a_ignored_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && r_seen && !i_accepted |->
            i_drive_payload == r_drive && i_motion_payload == r_motion
            && i_drive_stamp == r_dstamp && i_motion_stamp == r_mstamp)
        else $error("ignored item changed stored telemetry");

endmodule

bind can_signal_extract_compose canx_checker u_canx_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_telem.valid),
    .i_out_ready      (o_telem.ready),
    .i_accepted       (o_telem.accepted),
    .i_drive_payload  (o_telem.drive_payload),
    .i_motion_payload (o_telem.motion_payload),
    .i_drive_stamp    (o_telem.drive_stamp),
    .i_motion_stamp   (o_telem.motion_stamp),
    .i_acc_total      (o_telem.accepted_total),
    .i_ign_total      (o_telem.ignored_total)
);
`default_nettype wire
